FILE: src/tpb_pkg.sv
// Shared constants, types and helpers for the temporal pixel blend.
// No dependencies; imported by every module of the block.
`default_nettype none
package tpb_pkg;

  localparam int NUM_REFS    = 4;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;
  localparam int PIX_W       = CH_W * NUM_CH;
  localparam int SCORE_W     = 11;
  localparam int LUMA_W      = 18;
  localparam int WGT_W       = 23;
  localparam int RECIP_STEPS = 23;
  localparam int PROD_W      = CH_W + WGT_W;
  localparam int CNT_W       = $clog2(NUM_REFS + 1);
  localparam int WSUM_W      = WGT_W + $clog2(NUM_REFS);
  localparam int SSUM_W      = PROD_W + $clog2(NUM_REFS);
  localparam int NUM_W       = SSUM_W + 1;
  localparam int DEN_W       = WSUM_W + 1;
  localparam int LANE_LAT    = RECIP_STEPS + 2;
  localparam int MERGE_LAT   = 2;
  localparam int DIV_LAT     = CH_W + 1;
  localparam int TOTAL_LAT   = LANE_LAT + MERGE_LAT + DIV_LAT;

  localparam logic [SCORE_W-1:0] MIN_SCORE   = SCORE_W'(16);
  localparam logic [SCORE_W-1:0] RECIP_INIT  = SCORE_W'(8);
  localparam logic [LUMA_W:0]    DROP_MARGIN = (LUMA_W + 1)'(12000);
  localparam logic [9:0]         LUMA_K0     = 10'd114;
  localparam logic [9:0]         LUMA_K1     = 10'd587;
  localparam logic [9:0]         LUMA_K2     = 10'd299;

  typedef struct packed {
    logic [NUM_CH-1:0][PROD_W-1:0] prod;
    logic [WGT_W-1:0]              wgt;
    logic [LUMA_W-1:0]             luma;
    logic                          rel;
  } lane_out_t;

  typedef struct packed {
    logic [NUM_CH-1:0][SSUM_W-1:0] ssum;
    logic [WSUM_W-1:0]             wsum;
    logic                          used;
  } blend_sum_t;

  function automatic logic [LUMA_W-1:0] luma_of(input logic [PIX_W-1:0] pix);
    logic [LUMA_W-1:0] l0, l1, l2;
    l0 = LUMA_W'(pix[7:0]) * LUMA_W'(LUMA_K0);
    l1 = LUMA_W'(pix[15:8]) * LUMA_W'(LUMA_K1);
    l2 = LUMA_W'(pix[23:16]) * LUMA_W'(LUMA_K2);
    return l0 + l1 + l2;
  endfunction

endpackage
`default_nettype wire

FILE: src/tpb_lane.sv
// One reference lane: luminance, pipelined reciprocal weight 2^26/max(16,score),
// and per-channel weighted products. Depends on tpb_pkg.
`default_nettype none
module tpb_lane (
  input  logic                       clk_i,
  input  logic                       adv_i,
  input  logic [tpb_pkg::PIX_W-1:0]   pixel_i,
  input  logic [tpb_pkg::SCORE_W-1:0] score_i,
  input  logic                       reliable_i,
  output tpb_pkg::lane_out_t          lane_o
);
  import tpb_pkg::*;

  logic [SCORE_W-1:0] r_q   [0:RECIP_STEPS];
  logic [SCORE_W-1:0] d_q   [0:RECIP_STEPS];
  logic [WGT_W-1:0]   q_q   [0:RECIP_STEPS];
  logic [PIX_W-1:0]   pix_q [0:RECIP_STEPS];
  logic [LUMA_W-1:0]  luma_q[0:RECIP_STEPS];
  logic               rel_q [0:RECIP_STEPS];
  lane_out_t          out_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r_q[0]    <= RECIP_INIT;
      d_q[0]    <= (score_i < MIN_SCORE) ? MIN_SCORE : score_i;
      q_q[0]    <= '0;
      pix_q[0]  <= pixel_i;
      luma_q[0] <= luma_of(pixel_i);
      rel_q[0]  <= reliable_i;
    end
  end

  for (genvar k = 0; k < RECIP_STEPS; k++) begin : g_step
    logic [SCORE_W:0]   t;
    logic               ge;
    logic [SCORE_W-1:0] r_d;
    assign t   = {r_q[k], 1'b0};
    assign ge  = t >= {1'b0, d_q[k]};
    assign r_d = ge ? SCORE_W'(t - {1'b0, d_q[k]}) : SCORE_W'(t);
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        r_q[k+1]    <= r_d;
        d_q[k+1]    <= d_q[k];
        q_q[k+1]    <= {q_q[k][WGT_W-2:0], ge};
        pix_q[k+1]  <= pix_q[k];
        luma_q[k+1] <= luma_q[k];
        rel_q[k+1]  <= rel_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int c = 0; c < NUM_CH; c++) begin
        out_q.prod[c] <= PROD_W'(pix_q[RECIP_STEPS][CH_W*c +: CH_W]) *
                         PROD_W'(q_q[RECIP_STEPS]);
      end
      out_q.wgt  <= q_q[RECIP_STEPS];
      out_q.luma <= luma_q[RECIP_STEPS];
      out_q.rel  <= rel_q[RECIP_STEPS];
    end
  end

  assign lane_o = out_q;
endmodule
`default_nettype wire

FILE: src/tpb_merge.sv
// Merge stage: median of reliable lumas by rank, outlier drop, and weighted sums.
// Two register stages. Depends on tpb_pkg.
`default_nettype none
module tpb_merge (
  input  logic                                clk_i,
  input  logic                                adv_i,
  input  tpb_pkg::lane_out_t [tpb_pkg::NUM_REFS-1:0] lanes_i,
  output tpb_pkg::blend_sum_t                 sum_o
);
  import tpb_pkg::*;

  lane_out_t [NUM_REFS-1:0] lanes_q;
  logic [LUMA_W-1:0]        med_q;
  logic                     used_q;
  blend_sum_t               sum_q;

  logic [CNT_W-1:0]  n_c, half_c;
  logic [CNT_W-1:0]  lt_c [NUM_REFS];
  logic [CNT_W-1:0]  le_c [NUM_REFS];
  logic [LUMA_W-1:0] med_c;

  // median = value whose rank window covers index n/2
  always_comb begin
    n_c = '0;
    for (int i = 0; i < NUM_REFS; i++) n_c = n_c + CNT_W'(lanes_i[i].rel);
    half_c = n_c >> 1;
    med_c  = '0;
    for (int i = 0; i < NUM_REFS; i++) begin
      lt_c[i] = '0;
      le_c[i] = '0;
      for (int j = 0; j < NUM_REFS; j++) begin
        lt_c[i] = lt_c[i] + CNT_W'(lanes_i[j].rel && (lanes_i[j].luma <  lanes_i[i].luma));
        le_c[i] = le_c[i] + CNT_W'(lanes_i[j].rel && (lanes_i[j].luma <= lanes_i[i].luma));
      end
      if (lanes_i[i].rel && (lt_c[i] <= half_c) && (half_c < le_c[i])) begin
        med_c = med_c | lanes_i[i].luma;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lanes_q <= lanes_i;
      med_q   <= med_c;
      used_q  <= n_c >= CNT_W'(2);
    end
  end

  blend_sum_t sum_c;
  logic       keep;
  always_comb begin
    sum_c      = '0;
    sum_c.used = used_q;
    keep       = 1'b0;
    for (int i = 0; i < NUM_REFS; i++) begin
      keep = lanes_q[i].rel &&
             (({1'b0, lanes_q[i].luma} + DROP_MARGIN) >= {1'b0, med_q});
      if (keep) begin
        for (int c = 0; c < NUM_CH; c++) begin
          sum_c.ssum[c] = sum_c.ssum[c] + SSUM_W'(lanes_q[i].prod[c]);
        end
        sum_c.wsum = sum_c.wsum + WSUM_W'(lanes_q[i].wgt);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) sum_q <= sum_c;
  end

  assign sum_o = sum_q;
endmodule
`default_nettype wire

FILE: src/tpb_div.sv
// Pipelined restoring divider giving an 8-bit quotient, one bit per stage.
// Input register plus one stage per quotient bit. Depends on tpb_pkg.
`default_nettype none
module tpb_div (
  input  logic                      clk_i,
  input  logic                      adv_i,
  input  logic [tpb_pkg::NUM_W-1:0] num_i,
  input  logic [tpb_pkg::DEN_W-1:0] den_i,
  output logic [tpb_pkg::CH_W-1:0]  quo_o
);
  import tpb_pkg::*;

  logic [DEN_W-1:0] r_q  [0:CH_W];
  logic [DEN_W-1:0] d_q  [0:CH_W];
  logic [CH_W-1:0]  lo_q [0:CH_W];
  logic [CH_W-1:0]  q_q  [0:CH_W];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r_q[0]  <= DEN_W'(num_i >> CH_W);
      d_q[0]  <= den_i;
      lo_q[0] <= num_i[CH_W-1:0];
      q_q[0]  <= '0;
    end
  end

  for (genvar k = 0; k < CH_W; k++) begin : g_step
    logic [DEN_W:0]   t;
    logic             ge;
    logic [DEN_W-1:0] r_d;
    assign t   = {r_q[k], lo_q[k][CH_W-1]};
    assign ge  = t >= {1'b0, d_q[k]};
    assign r_d = ge ? DEN_W'(t - {1'b0, d_q[k]}) : DEN_W'(t);
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        r_q[k+1]  <= r_d;
        d_q[k+1]  <= d_q[k];
        lo_q[k+1] <= {lo_q[k][CH_W-2:0], 1'b0};
        q_q[k+1]  <= {q_q[k][CH_W-2:0], ge};
      end
    end
  end

  assign quo_o = q_q[CH_W];
endmodule
`default_nettype wire

FILE: src/temporal_pixel_blend.sv
// Temporal pixel blend: one masked pixel per beat from four reference pixels,
// with a result every clock as long as the output accepts each beat. The
// pipeline is made of the lane (input register, 23 reciprocal steps and the
// product register), the two merge stages and the 9-stage rounding divider.
// The whole pipeline holds while a finished beat waits at the output.
// Depends on tpb_pkg, tpb_lane, tpb_merge and tpb_div.
`default_nettype none
module temporal_pixel_blend (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tpb_pkg::PIX_W-1:0]   ref_pixel_0_i,
  input  logic [tpb_pkg::PIX_W-1:0]   ref_pixel_1_i,
  input  logic [tpb_pkg::PIX_W-1:0]   ref_pixel_2_i,
  input  logic [tpb_pkg::PIX_W-1:0]   ref_pixel_3_i,
  input  logic [tpb_pkg::SCORE_W-1:0] ref_score_0_i,
  input  logic [tpb_pkg::SCORE_W-1:0] ref_score_1_i,
  input  logic [tpb_pkg::SCORE_W-1:0] ref_score_2_i,
  input  logic [tpb_pkg::SCORE_W-1:0] ref_score_3_i,
  input  logic                        ref_reliable_0_i,
  input  logic                        ref_reliable_1_i,
  input  logic                        ref_reliable_2_i,
  input  logic                        ref_reliable_3_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tpb_pkg::PIX_W-1:0]   blended_pixel_o,
  output logic                        temporal_used_o
);
  import tpb_pkg::*;

  logic [TOTAL_LAT-1:0] vld_q, vld_d;
  logic                 adv;

  assign adv        = !vld_q[TOTAL_LAT-1] || out_ready_i;
  assign in_ready_o = adv;
  assign vld_d      = {vld_q[TOTAL_LAT-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  logic [PIX_W-1:0]   pix   [NUM_REFS];
  logic [SCORE_W-1:0] score [NUM_REFS];
  logic               rel   [NUM_REFS];
  assign pix   = '{ref_pixel_0_i, ref_pixel_1_i, ref_pixel_2_i, ref_pixel_3_i};
  assign score = '{ref_score_0_i, ref_score_1_i, ref_score_2_i, ref_score_3_i};
  assign rel   = '{ref_reliable_0_i, ref_reliable_1_i, ref_reliable_2_i,
                   ref_reliable_3_i};

  lane_out_t [NUM_REFS-1:0] lanes;

  for (genvar i = 0; i < NUM_REFS; i++) begin : g_lane
    tpb_lane u_lane (
      .clk_i      (clk_i),
      .adv_i      (adv),
      .pixel_i    (pix[i]),
      .score_i    (score[i]),
      .reliable_i (rel[i]),
      .lane_o     (lanes[i])
    );
  end

  blend_sum_t sums;

  tpb_merge u_merge (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .lanes_i (lanes),
    .sum_o   (sums)
  );

  logic [DEN_W-1:0] den;
  logic [CH_W-1:0]  quo [NUM_CH];
  assign den = {sums.wsum, 1'b0};

  for (genvar c = 0; c < NUM_CH; c++) begin : g_div
    logic [NUM_W-1:0] num;
    assign num = {sums.ssum[c], 1'b0} + NUM_W'(sums.wsum);
    tpb_div u_div (
      .clk_i (clk_i),
      .adv_i (adv),
      .num_i (num),
      .den_i (den),
      .quo_o (quo[c])
    );
  end

  logic used_q [DIV_LAT];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      used_q[0] <= sums.used;
      for (int k = 1; k < DIV_LAT; k++) used_q[k] <= used_q[k-1];
    end
  end

  assign out_valid_o     = vld_q[TOTAL_LAT-1];
  assign temporal_used_o = used_q[DIV_LAT-1];
  assign blended_pixel_o = used_q[DIV_LAT-1] ? {quo[2], quo[1], quo[0]} : '0;
endmodule
`default_nettype wire
